>>> rtl/core/ppls_pkg.sv
// shared widths, reset values, register codes and types of the pose proximity loop search
`default_nettype none
package ppls_pkg;

  localparam int POS_W   = 24;
  localparam int QUAT_W  = 16;
  localparam int DIST_W  = 50;
  localparam int COS_W   = 31;
  localparam int AGE_W   = 10;
  localparam int COUNT_W = 11;
  localparam int CFG_IDX_W = 1;

  localparam int DEPTH_DEF  = 1024;
  localparam int WINDOW_DEF = 50;

  localparam logic [DIST_W-1:0] DIST_SQ_RST = 50'd67108864;
  localparam logic [COS_W-1:0]  COS_RST     = 31'd1061684776;

  localparam logic [CFG_IDX_W-1:0] CFG_DIST_SQ_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_HALF_ANGLE = 1'd1;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } kf_t;

  localparam int KF_W = $bits(kf_t);

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/core/ppls_if.sv
// pose request and search result channel interfaces
`default_nettype none
interface ppls_pose_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ppls_pkg::POS_W-1:0]     pos_x;
  logic signed [ppls_pkg::POS_W-1:0]     pos_y;
  logic signed [ppls_pkg::POS_W-1:0]     pos_z;
  logic signed [ppls_pkg::QUAT_W-1:0]    quat_w;
  logic signed [ppls_pkg::QUAT_W-1:0]    quat_x;
  logic signed [ppls_pkg::QUAT_W-1:0]    quat_y;
  logic signed [ppls_pkg::QUAT_W-1:0]    quat_z;

  modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                  output ready);
endinterface

interface ppls_result_if;
  logic                               valid;
  logic                               ready;
  logic                               closure_found;
  logic [ppls_pkg::AGE_W-1:0]         match_age_index;
  logic [ppls_pkg::COUNT_W-1:0]       keyframe_count;

  modport source (output valid, closure_found, match_age_index, keyframe_count,
                  input ready);
  modport sink   (input valid, closure_found, match_age_index, keyframe_count,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/ppls_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ppls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/ppls_match.sv
// three stage distance and orientation compare of one stored keyframe against the new pose
`default_nettype none
module ppls_match #(
  parameter int AW = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              flush,
  input  wire ppls_pkg::tag_t                    tag_in,
  input  wire logic [AW-1:0]                     idx_in,
  input  wire ppls_pkg::kf_t                     kf,
  input  wire ppls_pkg::kf_t                     cur,
  input  wire logic [ppls_pkg::DIST_W-1:0]       dist_lim,
  input  wire logic [ppls_pkg::COS_W-1:0]        cos_lim,
  output      ppls_pkg::res_t                    res,
  output      logic [AW-1:0]                     res_idx
);

  localparam int DW = ppls_pkg::POS_W + 1;
  localparam int PW = 2 * ppls_pkg::QUAT_W;
  localparam int SW = 2 * DW;
  localparam int TW = PW + 2;

  // stage 1: differences and quaternion products
  ppls_pkg::tag_t       t1_r;
  logic [AW-1:0]        i1_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic signed [PW-1:0] pw_r, px_r, py_r, pz_r;
  logic signed [PW-1:0] pw_nxt, px_nxt, py_nxt, pz_nxt;

  // stage 2: squares and dot product
  ppls_pkg::tag_t       t2_r;
  logic [AW-1:0]        i2_r;
  logic signed [SW-1:0] sx_r, sy_r, sz_r;
  logic signed [SW-1:0] sx_nxt, sy_nxt, sz_nxt;
  logic signed [TW-1:0] dot_r;

  // stage 3: compares
  logic [ppls_pkg::DIST_W-1:0] d2;
  logic [TW-1:0]               adot;
  logic                        hit_nxt;

  assign pw_nxt = PW'(cur.quat_w) * PW'(kf.quat_w);
  assign px_nxt = PW'(cur.quat_x) * PW'(kf.quat_x);
  assign py_nxt = PW'(cur.quat_y) * PW'(kf.quat_y);
  assign pz_nxt = PW'(cur.quat_z) * PW'(kf.quat_z);

  assign sx_nxt = SW'(dx_r) * SW'(dx_r);
  assign sy_nxt = SW'(dy_r) * SW'(dy_r);
  assign sz_nxt = SW'(dz_r) * SW'(dz_r);

  assign d2 = ppls_pkg::DIST_W'($unsigned(sx_r)) + ppls_pkg::DIST_W'($unsigned(sy_r))
            + ppls_pkg::DIST_W'($unsigned(sz_r));
  assign adot = dot_r[TW-1] ? $unsigned(-dot_r) : $unsigned(dot_r);
  assign hit_nxt = (d2 < dist_lim) && (adot > TW'(cos_lim));

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      t1_r <= '0;
      t2_r <= '0;
      res  <= '0;
    end else begin
      t1_r <= tag_in;
      t2_r <= t1_r;
      res  <= '{valid: t2_r.valid, last: t2_r.last, hit: hit_nxt};
    end
    i1_r    <= idx_in;
    i2_r    <= i1_r;
    res_idx <= i2_r;
    dx_r    <= DW'(cur.pos_x) - DW'(kf.pos_x);
    dy_r    <= DW'(cur.pos_y) - DW'(kf.pos_y);
    dz_r    <= DW'(cur.pos_z) - DW'(kf.pos_z);
    pw_r    <= pw_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    pz_r    <= pz_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    sz_r    <= sz_nxt;
    dot_r   <= TW'(pw_r) + TW'(px_r) + TW'(py_r) + TW'(pz_r);
  end

endmodule
`default_nettype wire

>>> rtl/core/pose_proximity_loop_search_core.sv
// pose proximity loop search: keyframe ring in ram, serial oldest-first match scan
// no scan is run when WINDOW or fewer keyframes are held; otherwise the oldest
//   n = held - WINDOW entries are scanned (fewer on an early match)
// poses are taken only in idle; the single ram read port scans one keyframe per cycle
// reset: synchronous; ring empty, limits back to defaults, ram contents left undefined
//   and never read before written, so no clearing pass is run
`default_nettype none
module pose_proximity_loop_search_core #(
  parameter int DEPTH  = ppls_pkg::DEPTH_DEF,
  parameter int WINDOW = ppls_pkg::WINDOW_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ppls_pose_if.sink                            in_pose,
  ppls_result_if.source                        out_res,
  input  wire logic                            cfg_we,
  input  wire logic [ppls_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ppls_pkg::DIST_W-1:0]     cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int HW = $clog2(DEPTH + 1);
  localparam int OW = AW + 2;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   wp_r, wp_nxt;
  logic [HW-1:0]                   held_r, held_nxt;
  logic [AW-1:0]                   cur_addr_r, cur_addr_nxt;
  ppls_pkg::kf_t                   cur_r, cur_nxt;
  logic [HW-1:0]                   scan_n_r, scan_n_nxt;
  logic [HW-1:0]                   iss_cnt_r, iss_cnt_nxt;
  logic [AW-1:0]                   rd_addr_r, rd_addr_nxt;
  ppls_pkg::tag_t                  tag1_r, tag1_nxt;
  logic [AW-1:0]                   idx1_r, idx1_nxt;
  logic                            found_r, found_nxt;
  logic [AW-1:0]                   age_r, age_nxt;
  logic [ppls_pkg::DIST_W-1:0]     dist_r;
  logic [ppls_pkg::COS_W-1:0]      cos_r;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_found_r, out_found_nxt;
  logic [ppls_pkg::AGE_W-1:0]      out_age_r, out_age_nxt;
  logic [ppls_pkg::COUNT_W-1:0]    out_count_r, out_count_nxt;

  logic                            accept;
  logic                            issue;
  logic                            flush;
  logic [OW-1:0]                   old_sum;
  logic [AW-1:0]                   oldest;
  ppls_pkg::kf_t                   wr_kf;
  logic [ppls_pkg::KF_W-1:0]       rd_word;
  ppls_pkg::res_t                  mres;
  logic [AW-1:0]                   mres_idx;

  assign in_pose.ready = (state_r == ST_IDLE);
  assign accept        = in_pose.valid && in_pose.ready;
  assign issue         = (state_r == ST_SCAN) && (iss_cnt_r != scan_n_r);
  assign flush         = mres.valid && mres.hit;

  assign wr_kf = '{pos_x: in_pose.pos_x, pos_y: in_pose.pos_y, pos_z: in_pose.pos_z,
                   quat_w: in_pose.quat_w, quat_x: in_pose.quat_x,
                   quat_y: in_pose.quat_y, quat_z: in_pose.quat_z};

  assign out_res.valid           = out_valid_r;
  assign out_res.closure_found   = out_found_r;
  assign out_res.match_age_index = out_age_r;
  assign out_res.keyframe_count  = out_count_r;

  ppls_ram #(
    .WIDTH (ppls_pkg::KF_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wp_r),
    .wdata (wr_kf),
    .raddr (rd_addr_r),
    .rdata (rd_word)
  );

  ppls_match #(
    .AW (AW)
  ) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (flush),
    .tag_in   (tag1_r),
    .idx_in   (idx1_r),
    .kf       (ppls_pkg::kf_t'(rd_word)),
    .cur      (cur_r),
    .dist_lim (dist_r),
    .cos_lim  (cos_r),
    .res      (mres),
    .res_idx  (mres_idx)
  );

  // oldest held slot sits held slots behind the write pointer
  always_comb begin
    wp_nxt   = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    held_nxt = (held_r == HW'(DEPTH)) ? held_r : held_r + 1'b1;
    old_sum  = OW'(wp_nxt) + OW'(DEPTH) - OW'(held_nxt);
    oldest   = (old_sum >= OW'(DEPTH)) ? AW'(old_sum - OW'(DEPTH)) : AW'(old_sum);
  end

  always_comb begin
    state_nxt     = state_r;
    cur_addr_nxt  = cur_addr_r;
    cur_nxt       = cur_r;
    scan_n_nxt    = scan_n_r;
    iss_cnt_nxt   = iss_cnt_r;
    rd_addr_nxt   = rd_addr_r;
    found_nxt     = found_r;
    age_nxt       = age_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_found_nxt = out_found_r;
    out_age_nxt   = out_age_r;
    out_count_nxt = out_count_r;
    tag1_nxt      = '{valid: issue && !flush, last: iss_cnt_r == scan_n_r - 1'b1};
    idx1_nxt      = AW'(iss_cnt_r);

    if (issue) begin
      iss_cnt_nxt = iss_cnt_r + 1'b1;
      rd_addr_nxt = (rd_addr_r == AW'(DEPTH - 1)) ? '0 : rd_addr_r + 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cur_nxt      = wr_kf;
          cur_addr_nxt = wp_r;
          found_nxt    = 1'b0;
          age_nxt      = '0;
          iss_cnt_nxt  = '0;
          rd_addr_nxt  = oldest;
          scan_n_nxt   = held_nxt - HW'(WINDOW);
          state_nxt    = (held_nxt > HW'(WINDOW)) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (flush) begin
          found_nxt = 1'b1;
          age_nxt   = mres_idx;
          state_nxt = ST_DONE;
        end else if (mres.valid && mres.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_age_nxt   = ppls_pkg::AGE_W'(age_r);
          out_count_nxt = ppls_pkg::COUNT_W'(held_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      held_r      <= '0;
      tag1_r      <= '0;
      out_valid_r <= 1'b0;
      dist_r      <= ppls_pkg::DIST_SQ_RST;
      cos_r       <= ppls_pkg::COS_RST;
    end else begin
      state_r     <= state_nxt;
      tag1_r      <= tag1_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        wp_r   <= wp_nxt;
        held_r <= held_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          ppls_pkg::CFG_DIST_SQ_LIMIT:  dist_r <= cfg_data;
          ppls_pkg::CFG_COS_HALF_ANGLE: cos_r  <= ppls_pkg::COS_W'(cfg_data);
          default: ;
        endcase
      end
    end
    cur_addr_r  <= cur_addr_nxt;
    cur_r       <= cur_nxt;
    scan_n_r    <= scan_n_nxt;
    iss_cnt_r   <= iss_cnt_nxt;
    rd_addr_r   <= rd_addr_nxt;
    idx1_r      <= idx1_nxt;
    found_r     <= found_nxt;
    age_r       <= age_nxt;
    out_found_r <= out_found_nxt;
    out_age_r   <= out_age_nxt;
    out_count_r <= out_count_nxt;
  end

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HW'(DEPTH))
    else $error("held count above ring depth");

  a_wp_follows_held: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != HW'(DEPTH)) |-> (wp_r == AW'(held_r)))
    else $error("write pointer out of step with held count");

  a_scan_skips_newest: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (rd_addr_r != cur_addr_r))
    else $error("scan reads the entry just written");

  a_match_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mres.valid |-> (state_r == ST_SCAN))
    else $error("compare result outside a scan");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_res.ready) |=> (state_r == ST_DONE))
    else $error("result dropped while output stalled");

endmodule
`default_nettype wire
